// File: src/frustum_sphere_culler_defines.svh
// Assertion macros for the files that check their own logic.
`ifndef FRUSTUM_SPHERE_CULLER_DEFINES_SVH
`define FRUSTUM_SPHERE_CULLER_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define FSC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define FSC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fsc_pkg.sv
package fsc_pkg;

  // Fixed-point format and datapath sizes.
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int PLANE_COUNT = 6;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = DATA_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  // Planes whose raw component is column three plus the selected column.
  localparam logic [PLANE_COUNT-1:0] PLANE_PLUS = 6'b100110;

  // Operation codes of an input word.
  localparam logic [1:0] OP_LOAD_P  = 2'd0;
  localparam logic [1:0] OP_LOAD_MV = 2'd1;
  localparam logic [1:0] OP_BUILD   = 2'd2;
  localparam logic [1:0] OP_TEST    = 2'd3;

  // Result kinds.
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_TEST  = 1'b1;

  // Modes of the root and divide unit.
  localparam logic RD_SQRT = 1'b0;
  localparam logic RD_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } rd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

  // Saturate a signed 64-bit value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] y;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      y = 32'h7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      y = 32'h8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

endpackage

// File: src/fsc_if.sv
// Input channel: one operation word per handshake.
interface fsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0] radius;
  logic        has_geometry;

  modport source (output valid, operation, element_index, element_value, center_x,
                  center_y, center_z, radius, has_geometry, input ready);
  modport sink (input valid, operation, element_index, element_value, center_x,
                center_y, center_z, radius, has_geometry, output ready);
endinterface

// Result channel: one result word per handshake.
interface fsc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       visible;
  logic [5:0] degenerate_planes;

  modport source (output valid, result_kind, visible, degenerate_planes, input ready);
  modport sink (input valid, result_kind, visible, degenerate_planes, output ready);
endinterface

// File: src/fsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/fsc_mul.sv
// Shared signed 32x32 multiplier with a registered product.
module fsc_mul import fsc_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// File: src/fsc_rootdiv.sv
// Iterative square root and restoring divider around one shared subtractor.
module fsc_rootdiv import fsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rd_ctl_t     ctl,
  input  logic [63:0] sq_in,
  input  logic [31:0] num_in,
  input  logic [31:0] den_in,
  output rd_stat_t    stat,
  output logic [31:0] root,
  output logic [30:0] quot
);

  logic              busy_r, done_r, mode_r;
  logic [STEP_W-1:0] cnt_r;
  logic [63:0]       v_r, r_r, bit_r;
  logic [DIV_STEPS-1:0] num_r, quo_r;
  logic [31:0]       rem_r;
  logic [32:0]       trial;
  logic [63:0]       cmp_a, cmp_b;
  logic [64:0]       diff;
  logic              geq, last;

  // One compare and subtract serves both modes.
  assign trial = {rem_r, num_r[DIV_STEPS-1]};
  assign cmp_a = (mode_r == RD_SQRT) ? v_r : {31'd0, trial};
  assign cmp_b = (mode_r == RD_SQRT) ? (r_r + bit_r) : {32'd0, den_in};
  assign diff  = {1'b0, cmp_a} - {1'b0, cmp_b};
  assign geq   = !diff[64];
  assign last  = (mode_r == RD_SQRT) ? (cnt_r == STEP_W'(SQRT_STEPS - 1))
                                     : (cnt_r == STEP_W'(DIV_STEPS - 1));

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Iteration datapath: one result bit per cycle.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_r <= ctl.mode;
      cnt_r  <= '0;
      v_r    <= sq_in;
      r_r    <= '0;
      bit_r  <= 64'd1 << 62;
      num_r  <= {num_in, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (mode_r == RD_SQRT) begin
        if (geq) begin
          v_r <= diff[63:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        rem_r <= geq ? diff[31:0] : trial[31:0];
        quo_r <= {quo_r[DIV_STEPS-2:0], geq};
        num_r <= {num_r[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root = r_r[31:0];
  assign quot = (|quo_r[DIV_STEPS-1:31]) ? 31'h7FFF_FFFF : quo_r[30:0];

endmodule

// File: src/frustum_sphere_culler.sv
// Channel | Dir | Word contents
// in_ch   | in  | operation, element_index, element_value, center_x/y/z, radius, has_geometry
// out_ch  | out | result_kind, visible, degenerate_planes
//
// A test works through each live plane with the shared multiplier and plane RAM; a test
// without geometry skips the planes. A build forms the matrix product, then per plane runs
// the 32-step square root and four 48-step divisions of the shared root and divide unit;
// a plane of zero length skips the divisions.
// rst_n is synchronous; after reset every plane is degenerate and all spheres pass.
// The block takes one word at a time and holds off input while a build or test runs;
// a finished result waits in the output register and does not block the next load.
`include "frustum_sphere_culler_defines.svh"

module frustum_sphere_culler import fsc_pkg::*; (
  input logic clk,
  input logic rst_n,
  fsc_in_if.sink    in_ch,
  fsc_out_if.source out_ch
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_MM_RD     = 5'd1;
  localparam logic [4:0] S_MM_MUL    = 5'd2;
  localparam logic [4:0] S_MM_ACC    = 5'd3;
  localparam logic [4:0] S_MM_WR     = 5'd4;
  localparam logic [4:0] S_PL_RD3    = 5'd5;
  localparam logic [4:0] S_PL_RDC    = 5'd6;
  localparam logic [4:0] S_PL_RAW    = 5'd7;
  localparam logic [4:0] S_SQ_MUL    = 5'd8;
  localparam logic [4:0] S_SQ_ACC    = 5'd9;
  localparam logic [4:0] S_SQRT_GO   = 5'd10;
  localparam logic [4:0] S_SQRT_WAIT = 5'd11;
  localparam logic [4:0] S_DIV_GO    = 5'd12;
  localparam logic [4:0] S_DIV_WAIT  = 5'd13;
  localparam logic [4:0] S_ZW        = 5'd14;
  localparam logic [4:0] S_TS_CHK    = 5'd15;
  localparam logic [4:0] S_TS_RD     = 5'd16;
  localparam logic [4:0] S_TS_MUL    = 5'd17;
  localparam logic [4:0] S_TS_ACC    = 5'd18;
  localparam logic [4:0] S_TS_D      = 5'd19;
  localparam logic [4:0] S_EMIT      = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [3:0] mi_r, mi_nxt;
  logic [1:0] k_r, k_nxt, j_r, j_nxt;
  logic [2:0] p_r, p_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic signed [31:0] raw_r [4];
  logic signed [31:0] raw_nxt;
  logic        raw_we;
  logic [31:0] len_r, len_nxt;
  logic [PLANE_COUNT-1:0] mask_r, mask_nxt, mask_new_r, mask_new_nxt;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0] rad_r;
  logic        res_kind_r, res_kind_nxt, res_vis_r, res_vis_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_vis_r;
  logic [PLANE_COUNT-1:0] out_deg_r;

  logic        in_fire, emit_fire;
  logic [31:0] p_rdata, mv_rdata, m_rdata, pl_rdata;
  logic [3:0]  p_raddr, mv_raddr, m_raddr;
  logic        m_we, pl_we;
  logic [31:0] pl_wdata;
  logic signed [31:0] mul_a, mul_b, raw_sel, center_sel;
  logic signed [63:0] prod_r, prod_sh;
  logic signed [63:0] tmp_ext, mc_ext, raw_sum, dist_sum, cull_chk;
  logic [31:0] raw_mag;
  logic [31:0] q_ext;
  rd_ctl_t     rd_ctl;
  rd_stat_t    rd_stat;
  logic [31:0] rd_root;
  logic [30:0] rd_quot;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign emit_fire   = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // Matrix stores, product matrix and plane coefficients.
  assign p_raddr  = {k_r, mi_r[1:0]};
  assign mv_raddr = {mi_r[3:2], k_r};

  fsc_ram #(.WIDTH(32), .DEPTH(16)) u_p_ram (
    .clk(clk), .we(in_fire && in_ch.operation == OP_LOAD_P),
    .waddr(in_ch.element_index), .wdata(in_ch.element_value),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  fsc_ram #(.WIDTH(32), .DEPTH(16)) u_mv_ram (
    .clk(clk), .we(in_fire && in_ch.operation == OP_LOAD_MV),
    .waddr(in_ch.element_index), .wdata(in_ch.element_value),
    .raddr(mv_raddr), .rdata(mv_rdata)
  );

  fsc_ram #(.WIDTH(32), .DEPTH(16)) u_m_ram (
    .clk(clk), .we(m_we), .waddr(mi_r), .wdata(sat32(acc_r)),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  fsc_ram #(.WIDTH(32), .DEPTH(24)) u_pl_ram (
    .clk(clk), .we(pl_we), .waddr({p_r, j_r}), .wdata(pl_wdata),
    .raddr({p_r, j_r}), .rdata(pl_rdata)
  );

  // Shared arithmetic units.
  fsc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  fsc_rootdiv u_rootdiv (
    .clk(clk), .rst_n(rst_n), .ctl(rd_ctl), .sq_in(acc_r), .num_in(raw_mag),
    .den_in(len_r), .stat(rd_stat), .root(rd_root), .quot(rd_quot)
  );

  // Datapath helpers.
  assign raw_sel    = raw_r[j_r];
  assign raw_mag    = raw_sel[31] ? (~raw_sel + 32'sd1) : raw_sel;
  assign center_sel = (j_r == 2'd0) ? cx_r : ((j_r == 2'd1) ? cy_r : cz_r);
  assign prod_sh    = prod_r >>> FRAC_BITS;
  assign tmp_ext    = {{32{tmp_r[31]}}, tmp_r};
  assign mc_ext     = {{32{m_rdata[31]}}, m_rdata};
  assign raw_sum    = PLANE_PLUS[p_r] ? (tmp_ext + mc_ext) : (tmp_ext - mc_ext);
  assign dist_sum   = acc_r + {{32{pl_rdata[31]}}, pl_rdata};
  assign cull_chk   = dist_sum + $signed({33'd0, rad_r});
  assign q_ext      = {1'b0, rd_quot};

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    mi_nxt       = mi_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    p_nxt        = p_r;
    acc_nxt      = acc_r;
    tmp_nxt      = tmp_r;
    raw_nxt      = raw_sel;
    raw_we       = 1'b0;
    len_nxt      = len_r;
    mask_new_nxt = mask_new_r;
    res_kind_nxt = res_kind_r;
    res_vis_nxt  = res_vis_r;
    m_we         = 1'b0;
    m_raddr      = {j_r, 2'd3};
    pl_we        = 1'b0;
    pl_wdata     = '0;
    mul_a        = '0;
    mul_b        = '0;
    rd_ctl.start = 1'b0;
    rd_ctl.mode  = RD_SQRT;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.operation == OP_BUILD) begin
          mi_nxt       = '0;
          k_nxt        = '0;
          acc_nxt      = '0;
          mask_new_nxt = '0;
          res_kind_nxt = KIND_BUILD;
          res_vis_nxt  = 1'b0;
          state_nxt    = S_MM_RD;
        end else if (in_fire && in_ch.operation == OP_TEST) begin
          res_kind_nxt = KIND_TEST;
          res_vis_nxt  = 1'b1;
          p_nxt        = '0;
          state_nxt    = in_ch.has_geometry ? S_TS_CHK : S_EMIT;
        end
      end
      S_MM_RD: state_nxt = S_MM_MUL;
      S_MM_MUL: begin
        mul_a     = mv_rdata;
        mul_b     = p_rdata;
        state_nxt = S_MM_ACC;
      end
      S_MM_ACC: begin
        acc_nxt = acc_r + prod_sh;
        if (k_r == 2'd3) begin
          state_nxt = S_MM_WR;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_MM_RD;
        end
      end
      S_MM_WR: begin
        m_we    = 1'b1;
        acc_nxt = '0;
        k_nxt   = '0;
        if (mi_r == 4'd15) begin
          p_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_PL_RD3;
        end else begin
          mi_nxt    = mi_r + 4'd1;
          state_nxt = S_MM_RD;
        end
      end
      S_PL_RD3: state_nxt = S_PL_RDC;
      S_PL_RDC: begin
        m_raddr   = {j_r, p_r[2:1]};
        tmp_nxt   = m_rdata;
        state_nxt = S_PL_RAW;
      end
      S_PL_RAW: begin
        raw_we  = 1'b1;
        raw_nxt = sat32(raw_sum);
        if (j_r == 2'd3) begin
          j_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_SQ_MUL;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_PL_RD3;
        end
      end
      S_SQ_MUL: begin
        mul_a     = raw_sel;
        mul_b     = raw_sel;
        state_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        acc_nxt = acc_r + prod_r;
        if (j_r == 2'd2) begin
          state_nxt = S_SQRT_GO;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQRT_GO: begin
        rd_ctl.start = 1'b1;
        rd_ctl.mode  = RD_SQRT;
        state_nxt    = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (rd_stat.done) begin
          len_nxt = rd_root;
          j_nxt   = '0;
          if (rd_root == '0) begin
            mask_new_nxt[p_r] = 1'b1;
            state_nxt         = S_ZW;
          end else begin
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_DIV_GO: begin
        rd_ctl.start = 1'b1;
        rd_ctl.mode  = RD_DIV;
        state_nxt    = S_DIV_WAIT;
      end
      S_DIV_WAIT, S_ZW: begin
        if (state_r == S_ZW || rd_stat.done) begin
          pl_we    = 1'b1;
          pl_wdata = (state_r == S_ZW) ? '0 : (raw_sel[31] ? (~q_ext + 32'd1) : q_ext);
          if (j_r != 2'd3) begin
            j_nxt     = j_r + 2'd1;
            state_nxt = (state_r == S_ZW) ? S_ZW : S_DIV_GO;
          end else if (p_r == 3'(PLANE_COUNT - 1)) begin
            state_nxt = S_EMIT;
          end else begin
            p_nxt     = p_r + 3'd1;
            j_nxt     = '0;
            state_nxt = S_PL_RD3;
          end
        end
      end
      S_TS_CHK: begin
        if (mask_r[p_r]) begin
          if (p_r == 3'(PLANE_COUNT - 1)) begin
            res_vis_nxt = 1'b1;
            state_nxt   = S_EMIT;
          end else begin
            p_nxt = p_r + 3'd1;
          end
        end else begin
          j_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_TS_RD;
        end
      end
      S_TS_RD: state_nxt = (j_r == 2'd3) ? S_TS_D : S_TS_MUL;
      S_TS_MUL: begin
        mul_a     = pl_rdata;
        mul_b     = center_sel;
        state_nxt = S_TS_ACC;
      end
      S_TS_ACC: begin
        acc_nxt   = acc_r + prod_sh;
        j_nxt     = j_r + 2'd1;
        state_nxt = S_TS_RD;
      end
      S_TS_D: begin
        if (cull_chk[63] || cull_chk == '0) begin
          res_vis_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end else if (p_r == 3'(PLANE_COUNT - 1)) begin
          res_vis_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          p_nxt     = p_r + 3'd1;
          state_nxt = S_TS_CHK;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The new mask takes effect when its build result is loaded.
  assign mask_nxt = (emit_fire && res_kind_r == KIND_BUILD) ? mask_new_r : mask_r;
  assign out_valid_nxt = emit_fire || (out_valid_r && !out_ch.ready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    mi_r       <= mi_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    tmp_r      <= tmp_nxt;
    len_r      <= len_nxt;
    mask_new_r <= mask_new_nxt;
    res_kind_r <= res_kind_nxt;
    res_vis_r  <= res_vis_nxt;
    if (raw_we) begin
      raw_r[j_r] <= raw_nxt;
    end
    if (in_fire && in_ch.operation == OP_TEST) begin
      cx_r  <= in_ch.center_x;
      cy_r  <= in_ch.center_y;
      cz_r  <= in_ch.center_z;
      rad_r <= in_ch.radius;
    end
    if (emit_fire) begin
      out_kind_r <= res_kind_r;
      out_vis_r  <= res_vis_r;
      out_deg_r  <= (res_kind_r == KIND_BUILD) ? mask_new_r : mask_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.result_kind       = out_kind_r;
  assign out_ch.visible           = out_vis_r;
  assign out_ch.degenerate_planes = out_deg_r;

  // Checks on the sequencer and the result register.
  `FSC_ASSERT_IMP(a_unit_busy_in_wait, rd_stat.busy, state_r == S_SQRT_WAIT || state_r == S_DIV_WAIT, "root/divide unit busy outside its wait states")
  `FSC_ASSERT_IMP(a_build_mask_match, out_valid_r && out_kind_r == KIND_BUILD, out_deg_r == mask_r, "build result mask differs from live mask")
  `FSC_ASSERT_IMP(a_no_planes_visible, out_valid_r && out_kind_r == KIND_TEST && out_deg_r == '1, out_vis_r, "sphere culled with every plane degenerate")
  `FSC_ASSERT_NXT(a_emit_shows_word, emit_fire, out_ch.valid && state_r == S_IDLE, "loaded result word not presented")

endmodule

// File: tb/frustum_sphere_culler_test.sv
module frustum_sphere_culler_test;
  import fsc_pkg::*;

  localparam int ITEM_COUNT  = 1450;
  localparam int CYCLE_LIMIT = 15000000;
  localparam int DRAIN_WAIT  = 120;

  typedef struct {
    logic [1:0]         op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        rad;
    logic               geo;
  } cull_word_t;

  typedef struct {
    logic       kind;
    logic       vis;
    logic [5:0] deg;
  } cull_answer_t;

  // Keeps a copy of the culler state and the answers still owed by the block.
  class cull_scoreboard;
    logic signed [31:0] proj_m[16];
    logic signed [31:0] view_m[16];
    logic signed [31:0] planes[24];
    logic [5:0]         deg_mask;
    cull_answer_t       owed[$];
    int                 mismatches;

    function new();
      foreach (planes[i]) planes[i] = '0;
      deg_mask = '1;
      mismatches = 0;
    endfunction

    function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic [31:0] unit_scale(longint x, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (x < 0) ? longint'(-x) : longint'(x);
      q = (mag << FRAC_BITS) / len;
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return (x < 0) ? -q[31:0] : q[31:0];
    endfunction

    // Forms the combined matrix, extracts and normalizes the six planes.
    function automatic logic [5:0] rebuild_planes();
      longint m[16];
      longint raw[4];
      longint acc;
      longint unsigned sq;
      longint unsigned len;
      logic [5:0] mask;
      mask = '0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int k = 0; k < 4; k++)
            acc += (longint'(view_m[4*r+k]) * longint'(proj_m[4*k+c])) >>> FRAC_BITS;
          m[4*r+c] = clamp32(acc);
        end
      end
      for (int p = 0; p < PLANE_COUNT; p++) begin
        sq = 0;
        for (int j = 0; j < 4; j++)
          raw[j] = clamp32(PLANE_PLUS[p] ? m[4*j+3] + m[4*j+p/2] : m[4*j+3] - m[4*j+p/2]);
        for (int j = 0; j < 3; j++) sq += longint'(raw[j] * raw[j]);
        len = int_root(sq);
        if (len == 0) begin
          mask[p] = 1'b1;
          for (int j = 0; j < 4; j++) planes[4*p+j] = '0;
        end else begin
          for (int j = 0; j < 4; j++) planes[4*p+j] = unit_scale(raw[j], len);
        end
      end
      return mask;
    endfunction

    function automatic logic sphere_visible(cull_word_t w);
      longint dist_sum;
      if (!w.geo) return 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (deg_mask[p]) continue;
        dist_sum = ((longint'(planes[4*p]) * longint'(w.cx)) >>> FRAC_BITS)
                 + ((longint'(planes[4*p+1]) * longint'(w.cy)) >>> FRAC_BITS)
                 + ((longint'(planes[4*p+2]) * longint'(w.cz)) >>> FRAC_BITS)
                 + longint'(planes[4*p+3]);
        if (dist_sum <= -longint'({1'b0, w.rad})) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Applies an accepted input word and queues the answer that a build or test owes.
    function void note_word(cull_word_t w);
      cull_answer_t a;
      case (w.op)
        OP_LOAD_P:  proj_m[w.idx] = w.val;
        OP_LOAD_MV: view_m[w.idx] = w.val;
        OP_BUILD: begin
          deg_mask = rebuild_planes();
          a.kind = KIND_BUILD;
          a.vis = 1'b0;
          a.deg = deg_mask;
          owed.push_back(a);
        end
        default: begin
          a.kind = KIND_TEST;
          a.vis = sphere_visible(w);
          a.deg = deg_mask;
          owed.push_back(a);
        end
      endcase
    endfunction

    function void check_answer(logic kind, logic vis, logic [5:0] deg);
      cull_answer_t a;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word kind=%0d", kind);
        return;
      end
      a = owed.pop_front();
      if (kind !== a.kind || vis !== a.vis || deg !== a.deg) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected kind=%0d vis=%0d deg=%02h, got %0d %0d %02h",
                   a.kind, a.vis, a.deg, kind, vis, deg);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   tx_idle;
  int   rx_idle;
  int   words_sent;
  int   cycles;
  cull_scoreboard sb;

  fsc_in_if  in_ch();
  fsc_out_if out_ch();

  frustum_sphere_culler dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Random backpressure on the result side.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle);
  end

  // Watches both channels; results are checked before new words are noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_answer(out_ch.result_kind, out_ch.visible, out_ch.degenerate_planes);
      if (in_ch.valid && in_ch.ready) begin
        cull_word_t w;
        w.op = in_ch.operation;
        w.idx = in_ch.element_index;
        w.val = in_ch.element_value;
        w.cx = in_ch.center_x;
        w.cy = in_ch.center_y;
        w.cz = in_ch.center_z;
        w.rad = in_ch.radius;
        w.geo = in_ch.has_geometry;
        sb.note_word(w);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(cull_word_t w);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= w.op;
    in_ch.element_index <= w.idx;
    in_ch.element_value <= w.val;
    in_ch.center_x <= w.cx;
    in_ch.center_y <= w.cy;
    in_ch.center_z <= w.cz;
    in_ch.radius <= w.rad;
    in_ch.has_geometry <= w.geo;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    // Idling follows progress through the run.
    if (words_sent < ITEM_COUNT / 3) begin
      tx_idle = 20;
      rx_idle = 76;
    end else if (words_sent < 2 * ITEM_COUNT / 3) begin
      tx_idle = 76;
      rx_idle = 20;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
  endtask

  function automatic cull_word_t noise_word(logic [1:0] op);
    cull_word_t w;
    w.op = op;
    w.idx = 4'($urandom);
    w.val = $urandom;
    w.cx = $urandom;
    w.cy = $urandom;
    w.cz = $urandom;
    w.rad = 31'($urandom);
    w.geo = 1'($urandom);
    return w;
  endfunction

  // Matrix element drawn from one of a few styles of matrix.
  function automatic logic signed [31:0] element_of(int style, int i);
    case (style)
      0: return (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
      1: return $urandom;
      2: return '0;
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  task automatic load_matrix(logic [1:0] op, int style);
    cull_word_t w;
    for (int i = 0; i < 16; i++) begin
      w = noise_word(op);
      w.idx = 4'(i);
      w.val = element_of(style, i);
      send_word(w);
    end
  endtask

  task automatic do_build();
    send_word(noise_word(OP_BUILD));
  endtask

  task automatic sphere_test(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic [30:0] r, logic g);
    cull_word_t w;
    w = noise_word(OP_TEST);
    w.cx = x;
    w.cy = y;
    w.cz = z;
    w.rad = r;
    w.geo = g;
    send_word(w);
  endtask

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(1 << 22)) - 32'sd2097152;
  endfunction

  // The extra edge lets the monitor note a word accepted at this same edge.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  initial begin
    cull_word_t w;
    bit mid_drained;
    sb = new();
    mid_drained = 1'b0;
    tx_idle = 20;
    rx_idle = 76;
    words_sent = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_LOAD_P;
    in_ch.element_index <= '0;
    in_ch.element_value <= '0;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.center_z <= '0;
    in_ch.radius <= '0;
    in_ch.has_geometry <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tests before any build: all planes are degenerate, so all pass.
    sphere_test(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, 1'b1);
    sphere_test(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, '0, 1'b0);

    // Identity matrices, then extremes, zero modelview and saturated elements.
    load_matrix(OP_LOAD_P, 0);
    load_matrix(OP_LOAD_MV, 0);
    do_build();
    sphere_test(32'sh0, 32'sh0, 32'sh0, '0, 1'b1);
    sphere_test(32'sh0005_0000, 32'sh0, 32'sh0, 31'h0001_0000, 1'b1);
    sphere_test(32'sh0005_0000, 32'sh0, 32'sh0, 31'h0001_0000, 1'b0);
    sphere_test(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0, 1'b1);
    sphere_test(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, 1'b1);
    load_matrix(OP_LOAD_MV, 2);
    do_build();
    sphere_test(32'sh7FFF_FFFF, 32'sh0, 32'sh0, '0, 1'b1);
    load_matrix(OP_LOAD_MV, 3);
    load_matrix(OP_LOAD_P, 3);
    do_build();
    sphere_test(near_coord(), near_coord(), near_coord(), '0, 1'b1);

    // Random part: mostly sphere tests against realistic planes, with rebuilds.
    while (words_sent < ITEM_COUNT) begin
      int pick;
      pick = $urandom_range(99);
      // Halfway through, the sender waits once for every owed result.
      if (!mid_drained && words_sent > ITEM_COUNT / 2) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      if (pick < 3) begin
        int style;
        style = $urandom_range(9) < 6 ? 4 : $urandom_range(3);
        load_matrix($urandom_range(1) ? OP_LOAD_P : OP_LOAD_MV, style);
        do_build();
      end else if (pick < 6) begin
        w = noise_word($urandom_range(1) ? OP_LOAD_P : OP_LOAD_MV);
        if ($urandom_range(1)) w.val = element_of(4, 0);
        send_word(w);
        if ($urandom_range(1)) do_build();
      end else if (pick < 14) begin
        send_word(noise_word(OP_TEST));
      end else begin
        sphere_test(near_coord(), near_coord(), near_coord(),
                    31'($urandom_range(1 << 20)), $urandom_range(15) != 0);
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/fsc_pkg.sv
src/fsc_if.sv
src/fsc_ram.sv
src/fsc_mul.sv
src/fsc_rootdiv.sv
src/frustum_sphere_culler.sv
tb/frustum_sphere_culler_test.sv
